/* src/text_cell_glyph_renderer_defines.svh */
// Assertion helpers for the text cell glyph renderer.
// TCGR_ASSERT_IMPL checks the consequent in the same cycle as the antecedent.
// TCGR_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef TEXT_CELL_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CELL_GLYPH_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCGR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcgr: same-cycle check failed");
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcgr: next-cycle check failed");
`else
`define TCGR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TCGR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/tcgr_pkg.sv */
package tcgr_pkg;

  // Default sizes of the glyph store
  localparam int MAX_CELL_HEIGHT_DEF = 16;
  localparam int GLYPH_COUNT_DEF     = 256;

  // Port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 216;
  localparam int COLOR_W     = 24;
  localparam int PIX_W       = 12;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_HEIGHT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR    = 3'd4;

  // Register reset values
  localparam logic [4:0]  CELL_HEIGHT_RST = 5'd16;
  localparam logic [9:0]  COLUMNS_RST     = 10'd128;
  localparam logic [8:0]  ROWS_RST        = 9'd48;
  localparam logic [23:0] FG_COLOR_RST    = 24'hFFFFFF;
  localparam logic [23:0] BG_COLOR_RST    = 24'h000000;

  // Item kinds and control characters
  localparam logic       KIND_LOAD  = 1'b1;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam int         TAB_STEP   = 4;

  // Datapath operations
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_NEWLINE = 3'd2;
  localparam logic [2:0] OP_RETURN  = 3'd3;
  localparam logic [2:0] OP_TAB     = 3'd4;
  localparam logic [2:0] OP_SETUP   = 3'd5;
  localparam logic [2:0] OP_ROW     = 3'd6;
  localparam logic [2:0] OP_ADVANCE = 3'd7;

  // Sequencing modes
  localparam logic [2:0] BR_NEXT       = 3'd0;
  localparam logic [2:0] BR_GOTO       = 3'd1;
  localparam logic [2:0] BR_WAIT_IN    = 3'd2;
  localparam logic [2:0] BR_DISPATCH   = 3'd3;
  localparam logic [2:0] BR_IF_OFFGRID = 3'd4;
  localparam logic [2:0] BR_UNTIL_LAST = 3'd5;

  // Program step addresses
  localparam logic [3:0] STEP_FETCH   = 4'd0;
  localparam logic [3:0] STEP_DECODE  = 4'd1;
  localparam logic [3:0] STEP_LOAD    = 4'd2;
  localparam logic [3:0] STEP_NEWLINE = 4'd3;
  localparam logic [3:0] STEP_RETURN  = 4'd4;
  localparam logic [3:0] STEP_TAB     = 4'd5;
  localparam logic [3:0] STEP_SETUP   = 4'd6;
  localparam logic [3:0] STEP_ROW     = 4'd7;
  localparam logic [3:0] STEP_ADVANCE = 4'd8;

  typedef struct packed {
    logic       in_rdy;
    logic [2:0] op;
    logic [2:0] br;
    logic [3:0] tgt;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [3:0] step);
    ucode_t w;
    case (step)
      STEP_FETCH:   w = '{1'b1, OP_NOP,     BR_WAIT_IN,    STEP_FETCH};
      STEP_DECODE:  w = '{1'b0, OP_NOP,     BR_DISPATCH,   STEP_FETCH};
      STEP_LOAD:    w = '{1'b0, OP_LOAD,    BR_GOTO,       STEP_FETCH};
      STEP_NEWLINE: w = '{1'b0, OP_NEWLINE, BR_GOTO,       STEP_FETCH};
      STEP_RETURN:  w = '{1'b0, OP_RETURN,  BR_GOTO,       STEP_FETCH};
      STEP_TAB:     w = '{1'b0, OP_TAB,     BR_GOTO,       STEP_FETCH};
      STEP_SETUP:   w = '{1'b0, OP_SETUP,   BR_IF_OFFGRID, STEP_ADVANCE};
      STEP_ROW:     w = '{1'b0, OP_ROW,     BR_UNTIL_LAST, STEP_FETCH};
      STEP_ADVANCE: w = '{1'b0, OP_ADVANCE, BR_GOTO,       STEP_FETCH};
      default:      w = '{1'b0, OP_NOP,     BR_GOTO,       STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* src/tcgr_ram.sv */
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/text_cell_glyph_renderer.sv */
// Channel   | Dir | Words                      | Fields (lowest bit first)
// s_axis    | in  | one character or glyph row | tuser: kind; tdata: char_code,
//           |     |                            |   glyph_row, glyph_bits
// m_axis    | out | one drawn glyph row        | tdata: pixel_x, pixel_y,
//           |     |                            |   color_0..color_7; tlast: last_row
// cfg       | in  | one register write         | cfg_index, cfg_data
//
// Steps: a load, newline, return or tab runs fetch, decode and its own step;
// a drawn character runs fetch, decode, setup, h rows (h = clamped height),
// advance; one row per cycle unless stalled, paced by the single store port.
// Reset: rst is synchronous; it clears the cursor, the sequencer and the
// registers to their defaults. The glyph store is not cleared.
// Stalls: m_axis_tready low holds the row loop; a new word is taken while the
// last drawn row still waits in the output register.

`include "text_cell_glyph_renderer_defines.svh"

module text_cell_glyph_renderer #(
  parameter int MAX_CELL_HEIGHT = tcgr_pkg::MAX_CELL_HEIGHT_DEF,
  parameter int GLYPH_COUNT     = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code, [11:8] glyph_row, [19:12] glyph_bits, [23:20] zero
  input  logic [tcgr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  // stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [47:24] color_0 ... [215:192] color_7
  output logic [tcgr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import tcgr_pkg::*;

  // Row counter, clamped height and glyph index widths
  localparam int RW    = $clog2(MAX_CELL_HEIGHT);
  localparam int HW    = $clog2(MAX_CELL_HEIGHT + 1);
  localparam int GW    = $clog2(GLYPH_COUNT);
  localparam int AW    = GW + RW;
  localparam int DEPTH = GLYPH_COUNT * (1 << RW);

  // Configuration registers
  logic [4:0]         cell_height;
  logic [9:0]         columns;
  logic [8:0]         rows;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  // Sequencer
  logic [3:0] pc;
  logic [3:0] pc_next;
  ucode_t     uc;

  // Latched input word
  logic       item_kind;
  logic [7:0] item_code;
  logic [3:0] item_row;
  logic [7:0] item_bits;

  // Cursor
  logic [9:0] col;
  logic [9:0] col_next;
  logic [8:0] line;
  logic [8:0] line_next;

  // Draw loop
  logic [RW-1:0]    row;
  logic [RW-1:0]    row_next;
  logic [RW-1:0]    hm1;
  logic [PIX_W-1:0] base_y;
  logic [HW-1:0]    eff_h;
  logic [8+HW:0]    prod_y;

  // Output register
  logic [PIX_W-1:0]   out_x;
  logic [PIX_W-1:0]   out_y;
  logic [COLOR_W-1:0] out_color [8];

  // Glyph store
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [GW-1:0] glyph;
  logic          row_ok;

  logic       in_acc;
  logic       slot_free;
  logic       emit;
  logic       is_last;
  logic       off_grid;
  logic [10:0] col_p1;
  logic [10:0] col_p4;
  logic [9:0]  line_p1;
  logic [8:0]  line_sat;

  assign uc            = ucode_rom(pc);
  assign s_axis_tready = uc.in_rdy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign emit      = (uc.op == OP_ROW) && slot_free;
  assign is_last   = (row == hm1);
  assign off_grid  = !((col < columns) && (line < rows));

  // Fold the code into the glyph range; the code is below twice the count
  assign glyph = (32'(item_code) >= GLYPH_COUNT) ?
                 GW'(32'(item_code) - GLYPH_COUNT) : GW'(item_code);
  assign row_ok = 32'(item_row) < MAX_CELL_HEIGHT;

  // Clamp the cell height to 1..MAX_CELL_HEIGHT
  always_comb begin
    if (cell_height == 5'd0) begin
      eff_h = HW'(1);
    end else if (32'(cell_height) > MAX_CELL_HEIGHT) begin
      eff_h = HW'(MAX_CELL_HEIGHT);
    end else begin
      eff_h = HW'(cell_height);
    end
  end

  assign prod_y = line * eff_h;

  // Next step
  always_comb begin
    case (uc.br)
      BR_NEXT:       pc_next = pc + 4'd1;
      BR_GOTO:       pc_next = uc.tgt;
      BR_WAIT_IN:    pc_next = in_acc ? pc + 4'd1 : pc;
      BR_DISPATCH: begin
        if (item_kind == KIND_LOAD) begin
          pc_next = STEP_LOAD;
        end else if (item_code == CH_NEWLINE) begin
          pc_next = STEP_NEWLINE;
        end else if (item_code == CH_RETURN) begin
          pc_next = STEP_RETURN;
        end else if (item_code == CH_TAB) begin
          pc_next = STEP_TAB;
        end else begin
          pc_next = STEP_SETUP;
        end
      end
      BR_IF_OFFGRID: pc_next = off_grid ? uc.tgt : pc + 4'd1;
      BR_UNTIL_LAST: pc_next = (emit && is_last) ? pc + 4'd1 : pc;
      default:       pc_next = STEP_FETCH;
    endcase
  end

  // Cursor moves, saturating at the grid size; an advance from the last column wraps
  assign col_p1   = {1'b0, col} + 11'd1;
  assign col_p4   = {1'b0, col} + 11'(TAB_STEP);
  assign line_p1  = {1'b0, line} + 10'd1;
  assign line_sat = (line_p1 > {1'b0, rows}) ? rows : line_p1[8:0];

  always_comb begin
    col_next  = col;
    line_next = line;
    case (uc.op)
      OP_NEWLINE: begin
        line_next = line_sat;
        col_next  = 10'd0;
      end
      OP_RETURN: col_next = 10'd0;
      OP_TAB:    col_next = (col_p4 > {1'b0, columns}) ? columns : col_p4[9:0];
      OP_ADVANCE: begin
        if (col_p1 == {1'b0, columns}) begin
          col_next  = 10'd0;
          line_next = line_sat;
        end else begin
          col_next = (col_p1 > {1'b0, columns}) ? columns : col_p1[9:0];
        end
      end
      default: ;
    endcase
  end

  // Address the row the next cycle works on, so the registered read lines up
  always_comb begin
    case (uc.op)
      OP_SETUP: row_next = '0;
      OP_ROW:   row_next = emit ? RW'(row + 1'b1) : row;
      default:  row_next = row;
    endcase
  end

  assign ram_we   = (uc.op == OP_LOAD) && row_ok;
  assign ram_addr = ram_we ? {glyph, RW'(item_row)} : {glyph, row_next};

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item_bits),
    .rdata (ram_rdata)
  );

  // Control state: sequencer, cursor, registers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= STEP_FETCH;
      col           <= '0;
      line          <= '0;
      m_axis_tvalid <= 1'b0;
      cell_height   <= CELL_HEIGHT_RST;
      columns       <= COLUMNS_RST;
      rows          <= ROWS_RST;
      fg_color      <= FG_COLOR_RST;
      bg_color      <= BG_COLOR_RST;
    end else begin
      pc   <= pc_next;
      col  <= col_next;
      line <= line_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // Drop writes beyond the register list
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CELL_HEIGHT: cell_height <= cfg_data[4:0];
          CFG_COLUMNS:     columns     <= cfg_data[9:0];
          CFG_ROWS:        rows        <= cfg_data[8:0];
          CFG_FG_COLOR:    fg_color    <= cfg_data;
          CFG_BG_COLOR:    bg_color    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload: latched word, loop setup, output row
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_kind <= s_axis_tuser;
      item_code <= s_axis_tdata[7:0];
      item_row  <= s_axis_tdata[11:8];
      item_bits <= s_axis_tdata[19:12];
    end
    row <= row_next;
    if (uc.op == OP_SETUP) begin
      hm1    <= RW'(eff_h - 1'b1);
      base_y <= prod_y[PIX_W-1:0];
    end
    if (emit) begin
      out_x        <= {col[8:0], 3'b000};
      out_y        <= base_y + PIX_W'(row);
      m_axis_tlast <= is_last;
      for (int c = 0; c < 8; c++) begin
        out_color[c] <= ram_rdata[7-c] ? fg_color : bg_color;
      end
    end
  end

  always_comb begin
    m_axis_tdata[PIX_W-1:0]       = out_x;
    m_axis_tdata[2*PIX_W-1:PIX_W] = out_y;
    for (int c = 0; c < 8; c++) begin
      m_axis_tdata[2*PIX_W + c*COLOR_W +: COLOR_W] = out_color[c];
    end
  end

  // A taken word always goes to decode next
  `TCGR_ASSERT_NEXT(a_fetch_to_decode, clk, rst, in_acc, pc == STEP_DECODE)
  // The row counter stays inside the cell while drawing
  `TCGR_ASSERT_IMPL(a_row_in_cell, clk, rst, pc == STEP_ROW, row <= hm1)
  // Leaving the row loop leaves the last row waiting at the output
  `TCGR_ASSERT_IMPL(a_last_row_out, clk, rst,
    (pc == STEP_ADVANCE) && ($past(pc) == STEP_ROW), m_axis_tvalid && m_axis_tlast)

endmodule

/* dv/text_cell_glyph_renderer_tb.sv */
`timescale 1ns / 1ps

module text_cell_glyph_renderer_tb;
  import tcgr_pkg::*;

  // A write word carries the opposite kind of a glyph load.
  localparam logic KIND_CHAR     = ~KIND_LOAD;
  localparam int   GLYPH_ROWS    = MAX_CELL_HEIGHT_DEF;
  localparam int   PIXELS        = 8;
  // Longest quiet stretch of the block after its last row: a load or a
  // control code runs fetch, decode and its own step, a draw its advance.
  localparam int   SETTLE_CYCLES = 12;
  localparam int   MAX_REPORTS   = 50;
  localparam int   LINE_FOR_WRAP = 260;

  // One drawn glyph row as it leaves the block.
  typedef struct packed {
    logic [PIX_W-1:0]               px;
    logic [PIX_W-1:0]               py;
    logic [PIXELS-1:0][COLOR_W-1:0] color;
    logic                           last;
  } glyph_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;   // char_code, glyph_row, glyph_bits, zero pad
  logic                   s_axis_tuser;   // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // pixel_x, pixel_y, color_0 .. color_7
  logic                   m_axis_tlast;   // last_row
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Screen registers as the block should hold them.
  int unsigned        cell_h;
  int unsigned        n_cols;
  int unsigned        n_rows;
  logic [COLOR_W-1:0] fg_rgb;
  logic [COLOR_W-1:0] bg_rgb;

  // Cursor and font as the block should hold them.
  int unsigned           cur_col;
  int unsigned           cur_line;
  logic [7:0]            glyph_mem    [GLYPH_COUNT_DEF*GLYPH_ROWS];
  logic [GLYPH_ROWS-1:0] glyph_loaded [GLYPH_COUNT_DEF];
  logic [7:0]            font_codes[$];   // glyphs with every row written

  glyph_row_t expected_rows[$];

  int fail_count;
  bit idle_on;             // random gaps on both sides when set
  int sink_hold_cycles;    // long receiver hold-off, counted down by the sink

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  text_cell_glyph_renderer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Screen model
  // ---------------------------------------------------------------------

  function automatic int unsigned eff_height();
    if (cell_h < 1) return 1;
    if (cell_h > GLYPH_ROWS) return GLYPH_ROWS;
    return cell_h;
  endfunction

  // Add and clamp at the limit; a value already past the limit drops to it.
  function automatic int unsigned sat_step(int unsigned v, int unsigned inc,
                                           int unsigned lim);
    int unsigned s;
    s = v + inc;
    return (s > lim) ? lim : s;
  endfunction

  function automatic bit on_grid();
    return (cur_col < n_cols) && (cur_line < n_rows);
  endfunction

  function automatic bit is_control(logic [7:0] code);
    return (code == CH_NEWLINE) || (code == CH_RETURN) || (code == CH_TAB);
  endfunction

  // True when every row a draw of this glyph reads has been written.
  function automatic bit glyph_ready(logic [7:0] code);
    logic [GLYPH_ROWS:0] need;
    need = (1 << eff_height()) - 1;
    return (glyph_loaded[code] & need[GLYPH_ROWS-1:0]) == need[GLYPH_ROWS-1:0];
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_CELL_HEIGHT: cell_h = d[4:0];
      CFG_COLUMNS:     n_cols = d[9:0];
      CFG_ROWS:        n_rows = d[8:0];
      CFG_FG_COLOR:    fg_rgb = d;
      CFG_BG_COLOR:    bg_rgb = d;
      default: ;
    endcase
  endfunction

  // Update cursor and font for one accepted word and queue the glyph rows
  // that it draws.
  function automatic void predict_word(logic kind, logic [7:0] code,
                                       logic [3:0] grow, logic [7:0] gbits);
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [7:0]  bits;
    glyph_row_t  row;
    if (kind == KIND_LOAD) begin
      glyph_mem[code*GLYPH_ROWS + grow] = gbits;
      glyph_loaded[code][grow] = 1'b1;
      return;
    end
    case (code)
      CH_NEWLINE: begin
        cur_line = sat_step(cur_line, 1, n_rows);
        cur_col  = 0;
      end
      CH_RETURN: cur_col = 0;
      CH_TAB:    cur_col = sat_step(cur_col, TAB_STEP, n_cols);
      default: begin
        // Off-grid characters draw nothing but still move the cursor.
        if (on_grid()) begin
          h = eff_height();
          for (r = 0; r < h; r++) begin
            bits   = glyph_mem[code*GLYPH_ROWS + r];
            row.px = cur_col * PIXELS;
            row.py = cur_line * h + r;
            for (c = 0; c < PIXELS; c++)
              row.color[c] = bits[PIXELS-1-c] ? fg_rgb : bg_rgb;
            row.last = (r + 1 == h);
            expected_rows.push_back(row);
          end
        end
        if (cur_col + 1 == n_cols) begin
          cur_line = sat_step(cur_line, 1, n_rows);
          cur_col  = 0;
        end else begin
          cur_col = sat_step(cur_col, 1, n_cols);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // on return so the next word can follow without a bubble.
  task automatic send_word(logic kind, logic [7:0] code, logic [3:0] grow,
                           logic [7:0] gbits);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {4'b0, gbits, grow, code};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_word(kind, code, grow, gbits);
  endtask

  // Glyph_row and glyph_bits are don't-care on a write: fill them with noise.
  task automatic send_char(logic [7:0] code);
    send_word(KIND_CHAR, code, $urandom, $urandom);
  endtask

  // Write all rows of a glyph with random bits.
  task automatic load_glyph(logic [7:0] code);
    int r;
    if (glyph_loaded[code] != '1) font_codes.push_back(code);
    for (r = 0; r < GLYPH_ROWS; r++)
      send_word(KIND_LOAD, code, r, $urandom);
  endtask

  // Drop valid, wait for every queued row, then let the block go quiet.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    wait_idle();
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_screen(logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] cols,
                            logic [CFG_DATA_W-1:0] lines, logic [CFG_DATA_W-1:0] fg,
                            logic [CFG_DATA_W-1:0] bg);
    write_reg(CFG_CELL_HEIGHT, h);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, lines);
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks.
  initial begin : sink
    int stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        sink_hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        stall_left    = pick_gap();
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR [%0t] %s", $time, msg);
  endtask

  // Compare each accepted glyph row with the oldest expected one.
  always @(posedge clk) begin : check_rows
    glyph_row_t got;
    glyph_row_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[PIX_W-1:0];
      got.py = m_axis_tdata[2*PIX_W-1:PIX_W];
      for (int c = 0; c < PIXELS; c++)
        got.color[c] = m_axis_tdata[2*PIX_W + COLOR_W*c +: COLOR_W];
      got.last = m_axis_tlast;
      if (expected_rows.size() == 0) begin
        log_failure($sformatf("unexpected word x=%0d y=%0d", got.px, got.py));
      end else begin
        want = expected_rows.pop_front();
        if (got.px !== want.px)
          log_failure($sformatf("pixel_x got %0d expected %0d", got.px, want.px));
        if (got.py !== want.py)
          log_failure($sformatf("pixel_y got %0d expected %0d", got.py, want.py));
        for (int c = 0; c < PIXELS; c++)
          if (got.color[c] !== want.color[c])
            log_failure($sformatf("color_%0d at x=%0d y=%0d got %06h expected %06h",
                                  c, want.px, want.py, got.color[c], want.color[c]));
        if (got.last !== want.last)
          log_failure($sformatf("last_row at x=%0d y=%0d got %0b expected %0b",
                                want.px, want.py, got.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Small screen for the directed part: 6 x 3 cells, two rows per glyph.
  task automatic test_register_writes();
    set_screen(2, 6, 3, 24'h123456, 24'hFEDCBA);
  endtask

  // All-set and all-clear rows, a lone MSB and a lone LSB, the top glyph
  // index and the last glyph row.
  task automatic test_glyph_extremes();
    send_word(KIND_LOAD, 8'h00, 4'd0, 8'hFF);
    send_word(KIND_LOAD, 8'h00, 4'd1, 8'h00);
    send_word(KIND_LOAD, 8'hFF, 4'd0, 8'h80);
    send_word(KIND_LOAD, 8'hFF, 4'd1, 8'h01);
    send_word(KIND_LOAD, 8'h80, 4'd15, 8'hA5);
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  // Cursor at column 2 of line 0 on entry.
  task automatic test_control_codes();
    send_char(CH_TAB);       // lands exactly on the column limit
    send_char(CH_TAB);       // already at the limit: stays there
    send_char(CH_RETURN);
    send_char(CH_TAB);
    send_char(CH_NEWLINE);   // next line, column zero
    send_char(CH_TAB);
  endtask

  // Cursor at column 4 of line 1 on entry.
  task automatic test_wrap_and_offgrid();
    send_char(8'h00);
    send_char(8'hFF);        // last column: wrap to the next line
    send_char(8'h00);
    send_char(CH_TAB);
    send_char(CH_TAB);       // overshoots: clamps to the column limit
    send_char(8'h00);        // past the last column: dropped
    send_char(CH_NEWLINE);
    send_char(CH_NEWLINE);   // line clamps at the row limit
    send_char(8'hFF);        // below the last line: dropped
  endtask

  // Hold the receiver off while full-height characters keep coming, so the
  // output fills and the input stalls.
  task automatic test_backpressure();
    set_screen(CELL_HEIGHT_RST, COLUMNS_RST, ROWS_RST, FG_COLOR_RST, BG_COLOR_RST);
    idle_on = 1'b0;
    send_char(CH_RETURN);
    load_glyph(8'h41);
    sink_hold_cycles = 300;
    repeat (8) send_char(8'h41);
    idle_on = 1'b1;
  endtask

  // One random step: mostly drawn text, some control codes, some stray row
  // rewrites. A draw that would read unwritten rows loads the glyph first.
  task automatic random_step();
    int         r;
    logic [7:0] code;
    r    = $urandom_range(0, 99);
    code = $urandom;
    if (r < 4) begin
      send_char(CH_NEWLINE);
    end else if (r < 9) begin
      send_char(CH_RETURN);
    end else if (r < 15) begin
      send_char(CH_TAB);
    end else if (r < 27) begin
      send_word(KIND_LOAD, code, $urandom, $urandom);
    end else begin
      if (font_codes.size() != 0 && $urandom_range(0, 3) != 0)
        code = font_codes[$urandom_range(0, font_codes.size() - 1)];
      if (!is_control(code) && on_grid() && !glyph_ready(code)) load_glyph(code);
      send_char(code);
    end
  endtask

  // Random text across several screen setups. The cursor line never resets,
  // so some phases set their row limit relative to it.
  task automatic test_random_text();
    int          phase;
    int          steps;
    int unsigned lines;
    for (phase = 0; phase < 7; phase++) begin
      idle_on = (phase != 2) && (phase != 4);
      case (phase)
        0: begin
          set_screen(CELL_HEIGHT_RST, COLUMNS_RST, ROWS_RST, $urandom, $urandom);
          steps = 40;
        end
        1: begin
          // One column: every character drawn in it wraps.
          lines = (cur_line + 40 > 511) ? 511 : cur_line + 40;
          set_screen(1, 1, lines, 24'h000000, 24'hFFFFFF);
          steps = 30;
        end
        2: begin
          // Height above the store clamps; tab far right so pixel_x wraps.
          set_screen(31, 1023, 511, FG_COLOR_RST, BG_COLOR_RST);
          send_char(CH_RETURN);
          repeat (130) send_char(CH_TAB);
          steps = 30;
        end
        3: begin
          // Zero height clamps up to one row.
          set_screen(0, 512, 256, $urandom, $urandom);
          steps = 30;
        end
        4: begin
          lines = cur_line + $urandom_range(1, 64);
          if (lines > 511) lines = 511;
          set_screen($urandom_range(1, 16), $urandom_range(1, 512), lines,
                     $urandom, $urandom);
          steps = 40;
        end
        5: begin
          // No columns and one line: everything is off the grid.
          set_screen($urandom_range(0, 31), 0, 1, $urandom, $urandom);
          steps = 10;
        end
        default: begin
          // Push the cursor far down so pixel_y wraps.
          set_screen(16, 128, 511, $urandom, $urandom);
          while (cur_line < LINE_FOR_WRAP) send_char(CH_NEWLINE);
          steps = 40;
        end
      endcase
      repeat (steps) random_step();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = KIND_CHAR;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_CELL_HEIGHT;
    cfg_data         = '0;
    fail_count       = 0;
    idle_on          = 1'b1;
    sink_hold_cycles = 0;
    cell_h           = CELL_HEIGHT_RST;
    n_cols           = COLUMNS_RST;
    n_rows           = ROWS_RST;
    fg_rgb           = FG_COLOR_RST;
    bg_rgb           = BG_COLOR_RST;
    cur_col          = 0;
    cur_line         = 0;
    foreach (glyph_loaded[g]) glyph_loaded[g] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_writes();
    test_glyph_extremes();
    test_control_codes();
    test_wrap_and_offgrid();
    test_backpressure();
    test_random_text();

    wait_idle();
    if (fail_count == 0) begin
      $display("text_cell_glyph_renderer test passed");
    end else begin
      $display("text_cell_glyph_renderer test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("text_cell_glyph_renderer test failed");
    $finish;
  end

endmodule
